>>> rtl/sha256_message_hasher_core_macros.svh
// assertion macros for the sha-256 message hasher
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SHA256_MESSAGE_HASHER_CORE_MACROS_SVH
`define SHA256_MESSAGE_HASHER_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define SHAMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define SHAMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/shamh_pkg.sv
// shared types and constants of the sha-256 message hasher
// no dependencies
package shamh_pkg;

  // eight 32-bit words, element 0 is word a / hash word 0
  typedef logic [0:7][31:0] words8_t;

  localparam words8_t HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

>>> rtl/shamh_round.sv
// one sha-256 round: message schedule word and working variable update
// depends on shamh_pkg
module shamh_round (
  input  shamh_pkg::words8_t work_i,
  input  logic [511:0]       sched_i,
  input  logic [5:0]         round_i,
  output shamh_pkg::words8_t work_o,
  output logic [31:0]        w_o
);
  import shamh_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] w0, w1, w9, w14;
  logic [31:0] sig0, sig1, new_w;
  logic [31:0] bsig0, bsig1, ch, maj, t1, t2;

  // window word j sits at bits [511-32j -: 32], word 0 is the oldest
  assign w0  = sched_i[511:480];
  assign w1  = sched_i[479:448];
  assign w9  = sched_i[223:192];
  assign w14 = sched_i[63:32];

  assign sig0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign sig1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign new_w = sig1 + w9 + sig0 + w0;

  // first sixteen rounds use the block words as loaded
  assign w_o = (round_i[5:4] == 2'b00) ? w0 : new_w;

  assign bsig0 = rotr(work_i[0], 2) ^ rotr(work_i[0], 13) ^ rotr(work_i[0], 22);
  assign bsig1 = rotr(work_i[4], 6) ^ rotr(work_i[4], 11) ^ rotr(work_i[4], 25);
  assign ch    = (work_i[4] & work_i[5]) ^ (~work_i[4] & work_i[6]);
  assign maj   = (work_i[0] & work_i[1]) ^ (work_i[0] & work_i[2]) ^
                 (work_i[1] & work_i[2]);
  assign t1    = work_i[7] + bsig1 + ch + ROUND_K[round_i] + w_o;
  assign t2    = bsig0 + maj;

  always_comb begin
    work_o[0] = t1 + t2;
    work_o[1] = work_i[0];
    work_o[2] = work_i[1];
    work_o[3] = work_i[2];
    work_o[4] = work_i[3] + t1;
    work_o[5] = work_i[4];
    work_o[6] = work_i[5];
    work_o[7] = work_i[6];
  end

endmodule

>>> rtl/sha256_message_hasher_core.sv
// sha-256 message hasher, top level: byte intake, padding, round sequencer, digest output
// depends on shamh_pkg, shamh_round and sha256_message_hasher_core_macros.svh
//
// input channel: one beat per message byte (byte_valid_i) and/or end marker
// (end_of_message_i); a beat with neither changes nothing. output channel: eight
// beats per message, digest word 0 first, last_word_o on word 7.
// the 64th byte of a block starts a compression of 64 rounds on the shared
// round unit, then a fold into the hash, and in_stall_o stays high through
// both. an end beat then pushes the padding bytes one per cycle (up to 64 in
// one block, up to 72 when the length spills into a second block), with one
// or two compressions, then emits the eight digest beats.
// in_stall_o is high whenever the sequencer is not idle. out_stall_i holds the
// current digest beat in its output register and pauses the sequencer there.
// a bit count overflow makes the eight beats carry zero and length_error_o.
// after the last digest beat the hash state re-initializes for the next message.
// reset (rst_ni low, asynchronous) loads the initial hash values, clears the
// counters and flags and drops out_valid_o; no clearing pass is needed.
`include "sha256_message_hasher_core_macros.svh"

module sha256_message_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        byte_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        length_error_o,
  output logic        last_word_o
);
  import shamh_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  logic [2:0]   state_q, state_d;
  logic [5:0]   pos_q, pos_d;
  logic [63:0]  cnt_q, cnt_d;
  logic         ovf_q, ovf_d;
  logic         pad_q, pad_d;
  logic         first_q, first_d;
  logic         len_q, len_d;
  logic [5:0]   round_q, round_d;
  logic [2:0]   widx_q, widx_d;
  logic [511:0] blk_q, blk_d;
  words8_t      work_q, work_d;
  words8_t      hash_q, hash_d;

  logic         out_valid_q, out_valid_d;
  logic [31:0]  digest_q, digest_d;
  logic [2:0]   oidx_q, oidx_d;
  logic         oerr_q, oerr_d;
  logic         olast_q, olast_d;

  logic         in_fire, out_fire;
  logic         push;
  logic [7:0]   push_byte;
  logic [7:0]   len_byte;
  logic [63:0]  cnt_inc;
  logic         new_ovf, go_comp;
  words8_t      rnd_work;
  logic [31:0]  rnd_w;

  shamh_round u_round (
    .work_i  (work_q),
    .sched_i (blk_q),
    .round_i (round_q),
    .work_o  (rnd_work),
    .w_o     (rnd_w)
  );

  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign out_fire = out_valid_q && !out_stall_i;
  assign cnt_inc  = cnt_q + 64'd8;
  // big-endian length byte for block positions 56..63
  assign len_byte = 8'(cnt_q >> {~pos_q[2:0], 3'b000});

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    pad_d       = pad_q;
    first_d     = first_q;
    len_d       = len_q;
    round_d     = round_q;
    widx_d      = widx_q;
    blk_d       = blk_q;
    work_d      = work_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q;
    digest_d    = digest_q;
    oidx_d      = oidx_q;
    oerr_d      = oerr_q;
    olast_d     = olast_q;
    push        = 1'b0;
    push_byte   = '0;
    new_ovf     = ovf_q;
    go_comp     = 1'b0;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (byte_valid_i && !ovf_q) begin
            push      = 1'b1;
            push_byte = msg_byte_i;
            cnt_d     = cnt_inc;
            if (cnt_inc == '0) begin
              ovf_d   = 1'b1;
              new_ovf = 1'b1;
            end else if (pos_q == LAST_POS) begin
              go_comp = 1'b1;
            end
          end
          if (end_of_message_i) begin
            if (new_ovf) begin
              state_d = ST_OUT;
              widx_d  = '0;
            end else begin
              pad_d   = 1'b1;
              first_d = 1'b1;
              state_d = ST_PAD;
            end
          end
          if (go_comp) begin
            state_d = ST_ROUND;
            round_d = '0;
            work_d  = hash_q;
          end
        end
      end
      ST_PAD: begin
        push    = 1'b1;
        first_d = 1'b0;
        if (first_q) begin
          push_byte = PAD_MARK;
        end else if (len_q || pos_q == LEN_POS) begin
          push_byte = len_byte;
          len_d     = 1'b1;
        end
        if (pos_q == LAST_POS) begin
          state_d = ST_ROUND;
          round_d = '0;
          work_d  = hash_q;
        end
      end
      ST_ROUND: begin
        work_d  = rnd_work;
        blk_d   = {blk_q[479:0], rnd_w};
        round_d = round_q + 6'd1;
        if (round_q == LAST_ROUND) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + work_q[i];
        end
        if (len_q) begin
          state_d = ST_OUT;
          widx_d  = '0;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_fire) begin
          out_valid_d = 1'b1;
          digest_d    = ovf_q ? '0 : hash_q[widx_q];
          oidx_d      = widx_q;
          oerr_d      = ovf_q;
          olast_d     = (widx_q == LAST_WORD);
          widx_d      = widx_q + 3'd1;
          if (widx_q == LAST_WORD) begin
            hash_d  = HASH_INIT;
            pos_d   = '0;
            cnt_d   = '0;
            ovf_d   = 1'b0;
            pad_d   = 1'b0;
            first_d = 1'b0;
            len_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // bytes enter the low end and move up, so a full block has word 0 on top
    if (push) begin
      blk_d = {blk_q[503:0], push_byte};
      pos_d = pos_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      pad_q       <= 1'b0;
      first_q     <= 1'b0;
      len_q       <= 1'b0;
      round_q     <= '0;
      widx_q      <= '0;
      hash_q      <= HASH_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      pad_q       <= pad_d;
      first_q     <= first_d;
      len_q       <= len_d;
      round_q     <= round_d;
      widx_q      <= widx_d;
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    work_q   <= work_d;
    digest_q <= digest_d;
    oidx_q   <= oidx_d;
    oerr_q   <= oerr_d;
    olast_q  <= olast_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign digest_word_o  = digest_q;
  assign word_index_o   = oidx_q;
  assign length_error_o = oerr_q;
  assign last_word_o    = olast_q;

  `SHAMH_ASSERT_NEXT(a_round_to_fold, (state_q == ST_ROUND) && (round_q == LAST_ROUND),
    state_q == ST_FOLD, "compression did not fold after the last round")
  `SHAMH_ASSERT_NEXT(a_digest_continues, out_valid_o && !out_stall_i && !last_word_o,
    out_valid_o, "digest beats broke off before the last word")
  `SHAMH_ASSERT(a_error_zero, !(out_valid_o && length_error_o) || (digest_word_o == '0),
    "error beat carries a nonzero digest word")

endmodule
